// ===== src/sst_pkg.sv =====
`timescale 1ns / 1ps

package sst_pkg;

    localparam int KEY_W   = 32;
    localparam int RANK_W  = 4;
    localparam int COUNT_W = 5;
    localparam int CODE_W  = 2;
    localparam int S_DATA_W = 40;   // key_value, rank, zero fill
    localparam int M_DATA_W = 40;   // read_value, entry_count, zero fill

    localparam logic signed [KEY_W-1:0] READ_MISS = -32'sd1;

    typedef enum logic [CODE_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_READ   = 2'd2,
        OP_MERGE  = 2'd3
    } sst_op_t;

    typedef enum logic [CODE_W-1:0] {
        ST_DONE  = 2'd0,
        ST_MISS  = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } sst_status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_APPLY
    } sst_state_t;

    // Command broadcast to every cell of the row
    typedef struct packed {
        logic compare;
        logic ins;
        logic rem;
    } sst_cmd_t;

endpackage

// ===== src/sst_cell.sv =====
`timescale 1ns / 1ps

module sst_cell
(
    input  logic                                clk,
    input  sst_pkg::sst_cmd_t                   cmd,
    input  logic                                occupied,
    input  logic signed [sst_pkg::KEY_W-1:0]    key,
    input  logic                                left_lt,
    input  logic signed [sst_pkg::KEY_W-1:0]    left_value,
    input  logic signed [sst_pkg::KEY_W-1:0]    right_value,
    output logic signed [sst_pkg::KEY_W-1:0]    value,
    output logic                                lt,
    output logic                                eq
);

    logic signed [sst_pkg::KEY_W-1:0] value_reg;
    logic signed [sst_pkg::KEY_W-1:0] value_next;
    logic                             lt_reg;
    logic                             lt_next;
    logic                             eq_reg;
    logic                             eq_next;

    always_comb
    begin
        lt_next    = lt_reg;
        eq_next    = eq_reg;
        value_next = value_reg;
        if (cmd.compare)
        begin
            lt_next = occupied && (value_reg < key);
            eq_next = occupied && (value_reg == key);
        end
        // Cells past the insert/remove point move one place; the cell right
        // at the insert point takes the new key.
        if (cmd.ins && !lt_reg)
        begin
            value_next = left_lt ? key : left_value;
        end
        else if (cmd.rem && !lt_reg)
        begin
            value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        lt_reg    <= lt_next;
        eq_reg    <= eq_next;
    end

    assign value = value_reg;
    assign lt    = lt_reg;
    assign eq    = eq_reg;

endmodule

// ===== src/sorted_set_table.sv =====
`timescale 1ns / 1ps
// Flow: an accepted transaction passes the compare state, then the apply state, which waits
// until the master side is free and registers the result there. The cell row compares in the
// compare state and shifts in the apply state, and the next item enters during the shift.
// Reset: entry count and control cleared; cell contents are undefined until written and
// no clearing pass is run, so the block is ready as soon as reset is released.

module sorted_set_table
#(
    parameter int TABLE_DEPTH = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sst_pkg::S_DATA_W-1:0]  s_tdata,   // key_value[31:0], rank[35:32], zero[39:36]
    input  logic [sst_pkg::CODE_W-1:0]    s_tuser,   // opcode[1:0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sst_pkg::M_DATA_W-1:0]  m_tdata,   // read_value[31:0], entry_count[36:32],
                                                     // zero[39:37]
    output logic [sst_pkg::CODE_W-1:0]    m_tuser    // status[1:0]
);

    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W  = (CNT_W > sst_pkg::RANK_W) ? CNT_W : sst_pkg::RANK_W;
    localparam int READ_N = (TABLE_DEPTH < (1 << sst_pkg::RANK_W)) ?
                            TABLE_DEPTH : (1 << sst_pkg::RANK_W);

    sst_pkg::sst_state_t                 state_reg, state_next;
    sst_pkg::sst_op_t                    op_reg, op_next;
    logic signed [sst_pkg::KEY_W-1:0]    key_reg, key_next;
    logic [sst_pkg::RANK_W-1:0]          rank_reg, rank_next;
    logic [CNT_W-1:0]                    count_reg, count_next;
    logic                                out_valid_reg, out_valid_next;
    sst_pkg::sst_status_t                out_status_reg, out_status_next;
    logic signed [sst_pkg::KEY_W-1:0]    out_value_reg, out_value_next;
    logic [sst_pkg::COUNT_W-1:0]         out_count_reg, out_count_next;

    sst_pkg::sst_cmd_t                   cmd;
    logic signed [sst_pkg::KEY_W-1:0]    cell_value [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]              lt_vec;
    logic [TABLE_DEPTH-1:0]              eq_vec;
    logic [TABLE_DEPTH-1:0]              occ_vec;

    logic                                s_accept;
    logic                                out_free;
    logic                                found;
    logic                                full;
    logic                                rank_ok;
    logic signed [sst_pkg::KEY_W-1:0]    rank_value;

    // ---------------- cell row ----------------
    genvar i;
    generate
        for (i = 0; i < TABLE_DEPTH; i++)
        begin : g_cell
            logic                             left_lt_w;
            logic signed [sst_pkg::KEY_W-1:0] left_value_w;
            logic signed [sst_pkg::KEY_W-1:0] right_value_w;

            assign occ_vec[i] = (CNT_W'(i) < count_reg);

            if (i == 0)
            begin : g_first
                assign left_lt_w    = 1'b1;
                assign left_value_w = key_reg;
            end
            else
            begin : g_mid
                assign left_lt_w    = lt_vec[i-1];
                assign left_value_w = cell_value[i-1];
            end

            if (i == TABLE_DEPTH - 1)
            begin : g_last
                assign right_value_w = cell_value[i];
            end
            else
            begin : g_inner
                assign right_value_w = cell_value[i+1];
            end

            sst_cell u_cell
            (
                .clk         (clk),
                .cmd         (cmd),
                .occupied    (occ_vec[i]),
                .key         (key_reg),
                .left_lt     (left_lt_w),
                .left_value  (left_value_w),
                .right_value (right_value_w),
                .value       (cell_value[i]),
                .lt          (lt_vec[i]),
                .eq          (eq_vec[i])
            );
        end
    endgenerate

    // ---------------- flags and read port ----------------
    assign found   = |eq_vec;
    assign full    = (count_reg == CNT_W'(TABLE_DEPTH));
    assign rank_ok = (CMP_W'(rank_reg) < CMP_W'(count_reg));

    always_comb
    begin
        rank_value = '0;
        for (int j = 0; j < READ_N; j++)
        begin
            if (rank_reg == sst_pkg::RANK_W'(j))
                rank_value = cell_value[j];
        end
    end

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == sst_pkg::S_IDLE) ||
                      ((state_reg == sst_pkg::S_APPLY) && out_free);
    assign s_accept = s_tvalid && s_tready;

    // ---------------- control ----------------
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        rank_next       = rank_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_count_next  = out_count_reg;
        cmd             = '0;

        if (s_accept)
        begin
            op_next   = sst_pkg::sst_op_t'(s_tuser);
            key_next  = s_tdata[sst_pkg::KEY_W-1:0];
            rank_next = s_tdata[sst_pkg::KEY_W +: sst_pkg::RANK_W];
        end

        unique case (state_reg)
            sst_pkg::S_IDLE:
            begin
                if (s_accept)
                    state_next = sst_pkg::S_CMP;
            end
            sst_pkg::S_CMP:
            begin
                cmd.compare = 1'b1;
                state_next  = sst_pkg::S_APPLY;
            end
            sst_pkg::S_APPLY:
            begin
                if (out_free)
                begin
                    out_status_next = sst_pkg::ST_DONE;
                    out_value_next  = '0;
                    unique case (op_reg)
                        sst_pkg::OP_INSERT:
                        begin
                            if (found)
                                out_status_next = sst_pkg::ST_MISS;
                            else if (full)
                                out_status_next = sst_pkg::ST_FULL;
                            else
                            begin
                                cmd.ins    = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        sst_pkg::OP_REMOVE:
                        begin
                            if (found)
                            begin
                                cmd.rem    = 1'b1;
                                count_next = count_reg - CNT_W'(1);
                            end
                            else
                                out_status_next = sst_pkg::ST_MISS;
                        end
                        sst_pkg::OP_READ:
                        begin
                            if (rank_ok)
                                out_value_next = rank_value;
                            else
                            begin
                                out_status_next = sst_pkg::ST_RANGE;
                                out_value_next  = sst_pkg::READ_MISS;
                            end
                        end
                        sst_pkg::OP_MERGE:
                        begin
                            if (full)
                                out_status_next = sst_pkg::ST_FULL;
                            else
                            begin
                                cmd.ins    = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        default:
                        begin
                            out_status_next = sst_pkg::ST_DONE;
                        end
                    endcase
                    out_count_next = sst_pkg::COUNT_W'(count_next);
                    out_valid_next = 1'b1;
                    state_next     = s_accept ? sst_pkg::S_CMP : sst_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = sst_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sst_pkg::S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        rank_reg       <= rank_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
        out_count_reg  <= out_count_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {{(sst_pkg::M_DATA_W - sst_pkg::KEY_W - sst_pkg::COUNT_W){1'b0}},
                       out_count_reg, out_value_reg};

    // ---------------- assertions ----------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    // Sorted row: the less-than flags must form a prefix of the row
    a_lt_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == sst_pkg::S_APPLY |->
            $onehot({1'b0, lt_vec} + (TABLE_DEPTH + 1)'(1)))
        else $error("compare flags are not a prefix, table out of order");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != $past(count_reg) |-> $past(state_reg) == sst_pkg::S_APPLY)
        else $error("entry count changed outside the apply cycle");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == sst_pkg::S_APPLY)
        else $error("result raised without an applied transaction");

endmodule

// ===== verif/tb_sorted_set_table.sv =====
`timescale 1ns / 1ps

module tb_sorted_set_table;

    localparam int TABLE_DEPTH = 16;

    // traffic phases
    localparam logic [1:0] PH_STEADY     = 2'd0;
    localparam logic [1:0] PH_SRC_IDLE   = 2'd1;
    localparam logic [1:0] PH_SINK_STALL = 2'd2;
    localparam logic [1:0] PH_BOTH       = 2'd3;

    localparam int RANDOM_ITEMS = 900;
    localparam int SEGMENT_LEN  = 75;

    typedef struct packed {
        sst_pkg::sst_op_t                 op;
        logic signed [sst_pkg::KEY_W-1:0] key;
        logic [sst_pkg::RANK_W-1:0]       rank;
        logic [1:0]                       phase;
        logic                             drain;
    } table_op_t;

    typedef struct packed {
        sst_pkg::sst_status_t             status;
        logic signed [sst_pkg::KEY_W-1:0] read_value;
        logic [sst_pkg::COUNT_W-1:0]      entry_count;
    } table_res_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [sst_pkg::S_DATA_W-1:0]   s_tdata = '0;
    logic [sst_pkg::CODE_W-1:0]     s_tuser = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [sst_pkg::M_DATA_W-1:0]   m_tdata;
    logic [sst_pkg::CODE_W-1:0]     m_tuser;

    // shadow of the table contents
    logic signed [sst_pkg::KEY_W-1:0] table_vals [TABLE_DEPTH];
    int                               table_len = 0;

    table_op_t  ops_queued [$];
    table_res_t results_due [$];
    table_op_t  op_in_flight;
    table_res_t res_head;
    logic [1:0] cur_phase = PH_STEADY;
    int         errors = 0;

    sorted_set_table #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int src_idle_pct(logic [1:0] ph);
        if (ph == PH_SRC_IDLE)
            return 51;
        if (ph == PH_BOTH)
            return 15;
        return 0;
    endfunction

    function automatic int sink_stall_pct(logic [1:0] ph);
        if (ph == PH_SINK_STALL)
            return 51;
        if (ph == PH_BOTH)
            return 15;
        return 0;
    endfunction

    // Applies one operation to the shadow table and returns the result it produces.
    function automatic table_res_t table_apply(table_op_t t);
        table_res_t                       r;
        logic signed [sst_pkg::KEY_W-1:0] key;
        int                               pos;
        int                               i;
        logic                             hit;
        key = t.key;
        r.status = sst_pkg::ST_DONE;
        r.read_value = '0;
        pos = 0;
        while (pos < table_len && table_vals[pos] < key)
            pos++;
        hit = 1'b0;
        if (pos < table_len)
            hit = (table_vals[pos] == key);
        case (t.op)
            sst_pkg::OP_INSERT, sst_pkg::OP_MERGE:
            begin
                // duplicate check comes before the full check, merge keeps duplicates
                if (t.op == sst_pkg::OP_INSERT && hit)
                    r.status = sst_pkg::ST_MISS;
                else if (table_len >= TABLE_DEPTH)
                    r.status = sst_pkg::ST_FULL;
                else
                begin
                    for (i = table_len; i > pos; i--)
                        table_vals[i] = table_vals[i-1];
                    table_vals[pos] = key;
                    table_len++;
                end
            end
            sst_pkg::OP_REMOVE:
            begin
                if (hit)
                begin
                    for (i = pos; i + 1 < table_len; i++)
                        table_vals[i] = table_vals[i+1];
                    table_len--;
                end
                else
                    r.status = sst_pkg::ST_MISS;
            end
            default:
            begin
                if (t.rank >= table_len)
                begin
                    r.status = sst_pkg::ST_RANGE;
                    r.read_value = sst_pkg::READ_MISS;
                end
                else
                    r.read_value = table_vals[t.rank];
            end
        endcase
        r.entry_count = table_len[sst_pkg::COUNT_W-1:0];
        return r;
    endfunction

    task automatic queue_op(sst_pkg::sst_op_t op, logic [sst_pkg::KEY_W-1:0] key,
                            logic [sst_pkg::RANK_W-1:0] rank,
                            logic [1:0] phase, logic drain);
        table_op_t t;
        t.op = op;
        t.key = key;
        t.rank = rank;
        t.phase = phase;
        t.drain = drain;
        ops_queued.push_back(t);
    endtask

    // Mostly a narrow pool so inserts and removes collide, plus extremes and full-width values.
    function automatic logic [sst_pkg::KEY_W-1:0] pick_key();
        int roll;
        roll = $urandom_range(99);
        if (roll < 70)
            return sst_pkg::KEY_W'($signed($urandom_range(16)) - 8);
        if (roll < 80)
        begin
            case ($urandom_range(3))
                0: return 32'h8000_0000;
                1: return 32'h8000_0001;
                2: return 32'h7fff_fffe;
                default: return 32'h7fff_ffff;
            endcase
        end
        return $urandom;
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                results_due.push_back(table_apply(op_in_flight));
            if (!s_tvalid || s_tready)
            begin
                if (ops_queued.size() != 0 &&
                    (!ops_queued[0].drain || results_due.size() == 0) &&
                    $urandom_range(99) >= src_idle_pct(ops_queued[0].phase))
                begin
                    op_in_flight <= ops_queued[0];
                    cur_phase <= ops_queued[0].phase;
                    s_tdata <= {4'b0, ops_queued[0].rank, ops_queued[0].key};
                    s_tuser <= ops_queued[0].op;
                    s_tvalid <= 1'b1;
                    void'(ops_queued.pop_front());
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // monitor and sink
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (results_due.size() == 0)
                begin
                    $error("result transaction with nothing outstanding: tuser %0d tdata %h",
                           m_tuser, m_tdata);
                    errors++;
                end
                else
                begin
                    res_head = results_due.pop_front();
                    if (m_tuser !== res_head.status)
                    begin
                        $error("mismatch on status field: expected %0d, got %0d",
                               res_head.status, m_tuser);
                        errors++;
                    end
                    if (m_tdata[31:0] !== res_head.read_value)
                    begin
                        $error("mismatch on read_value: expected %0d, got %0d",
                               res_head.read_value, $signed(m_tdata[31:0]));
                        errors++;
                    end
                    if (m_tdata[36:32] !== res_head.entry_count)
                    begin
                        $error("mismatch on entry_count: expected %0d, got %0d",
                               res_head.entry_count, m_tdata[36:32]);
                        errors++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= sink_stall_pct(cur_phase));
        end
    end

    initial
    begin
        int                           i;
        int                           n;
        int                           made;
        int                           roll;
        int                           seg;
        logic [1:0]                   ph;
        logic                         grow;
        longint                       kv;
        logic [sst_pkg::KEY_W-1:0]    k;

        // directed: empty table, extremes, duplicates, then fill to capacity
        queue_op(sst_pkg::OP_READ,   32'd0,         4'd0,  PH_STEADY, 1'b0);
        queue_op(sst_pkg::OP_REMOVE, 32'd5,         4'd0,  PH_STEADY, 1'b0);
        queue_op(sst_pkg::OP_INSERT, 32'h7fff_ffff, 4'd15, PH_STEADY, 1'b0);
        queue_op(sst_pkg::OP_INSERT, 32'h8000_0000, 4'd0,  PH_STEADY, 1'b0);
        queue_op(sst_pkg::OP_INSERT, 32'd0,         4'd0,  PH_STEADY, 1'b0);
        queue_op(sst_pkg::OP_INSERT, 32'd0,         4'd0,  PH_STEADY, 1'b0);
        queue_op(sst_pkg::OP_MERGE,  32'd0,         4'd0,  PH_STEADY, 1'b0);
        queue_op(sst_pkg::OP_READ,   32'd0,         4'd1,  PH_STEADY, 1'b0);
        queue_op(sst_pkg::OP_READ,   32'd0,         4'd3,  PH_STEADY, 1'b0);
        queue_op(sst_pkg::OP_READ,   32'd0,         4'd15, PH_STEADY, 1'b0);
        queue_op(sst_pkg::OP_REMOVE, 32'd0,         4'd0,  PH_STEADY, 1'b0);
        // merge run of -1 and ascending values until the table is full
        for (i = 0; i < 13; i++)
            queue_op(sst_pkg::OP_MERGE, (i < 6) ? 32'hffff_ffff : 32'd100 * i, 4'd0,
                     PH_STEADY, 1'b0);
        queue_op(sst_pkg::OP_INSERT, 32'd12345,     4'd0,  PH_STEADY, 1'b0);
        queue_op(sst_pkg::OP_MERGE,  32'hffff_ffff, 4'd0,  PH_STEADY, 1'b0);
        queue_op(sst_pkg::OP_INSERT, 32'h7fff_ffff, 4'd0,  PH_STEADY, 1'b0);
        queue_op(sst_pkg::OP_READ,   32'd0,         4'd15, PH_STEADY, 1'b0);

        made = 0;
        grow = 1'b1;
        while (made < RANDOM_ITEMS)
        begin
            seg = made / SEGMENT_LEN;
            ph = seg[1:0];
            if (made % SEGMENT_LEN == 0)
                grow = $urandom_range(1);
            roll = $urandom_range(99);
            if (grow ? roll < 25 : roll < 10)
            begin
                // a short ascending merge run, duplicates allowed
                n = $urandom_range(5, 1);
                kv = $signed(pick_key());
                for (i = 0; i < n; i++)
                begin
                    k = kv[31:0];
                    queue_op(sst_pkg::OP_MERGE, k, sst_pkg::RANK_W'($urandom), ph,
                             (made % SEGMENT_LEN == 0) && (i == 0));
                    kv = kv + $urandom_range(3);
                    if (kv > 64'sd2147483647)
                        kv = 64'sd2147483647;
                end
                made += n;
            end
            else
            begin
                roll = $urandom_range(99);
                queue_op((grow ? roll < 45 : roll < 20) ? sst_pkg::OP_INSERT :
                         (grow ? roll < 70 : roll < 75) ? sst_pkg::OP_REMOVE :
                         sst_pkg::OP_READ,
                         pick_key(), sst_pkg::RANK_W'($urandom), ph,
                         made % SEGMENT_LEN == 0);
                made++;
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (ops_queued.size() != 0 || s_tvalid)
            @(posedge clk);
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule
